// ===== design/asst_pkg.sv =====
package asst_pkg;

    typedef enum logic [2:0] {
        ST_IDLE         = 3'd0,
        ST_HOLD         = 3'd1,
        ST_DWELL        = 3'd2,
        ST_ACTIVE       = 3'd3,
        ST_FORCE_ACTIVE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CFG_FIXED_THRESHOLD  = 3'd0,
        CFG_MARGIN_ENABLE    = 3'd1,
        CFG_NOISE_MARGIN     = 3'd2,
        CFG_DWELL_MS         = 3'd3,
        CFG_HOLD             = 3'd4,
        CFG_FORCE_ACTIVE     = 3'd5,
        CFG_DEBOUNCE_MS      = 3'd6,
        CFG_REPORT_PERIOD_MS = 3'd7
    } cfg_index_t;

    typedef enum logic {
        CMD_RSSI_UPDATE = 1'b0,
        CMD_STATUS_POLL = 1'b1
    } command_t;

    localparam logic signed [15:0] FIXED_THRESHOLD_RESET  = -16'sd7680;
    localparam logic signed [15:0] NOISE_MARGIN_RESET     = 16'sd1280;
    localparam logic [15:0]        DEBOUNCE_MS_RESET      = 16'd200;
    localparam logic [15:0]        REPORT_PERIOD_MS_RESET = 16'd1000;

    typedef struct packed {
        logic               command;
        logic [31:0]        timestamp_ms;
        logic signed [15:0] rssi;
        logic               raw_unmuted;
    } sample_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               report;
        logic               stable_unmuted;
        logic signed [15:0] effective_threshold;
        logic               threshold_changed;
        logic signed [15:0] noise_floor;
        logic               noise_floor_valid;
        logic signed [15:0] last_rssi;
    } result_t;

    typedef struct packed {
        cfg_index_t  index;
        logic [31:0] data;
    } cfg_write_t;

    // Noise floor as seen after the current transaction.
    typedef struct packed {
        logic               valid;
        logic signed [15:0] value;
    } floor_view_t;

endpackage

// ===== design/asst_sample_if.sv =====
interface asst_sample_if;
    logic              valid;
    logic              ready;
    asst_pkg::sample_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== design/asst_result_if.sv =====
interface asst_result_if;
    logic              valid;
    logic              ready;
    asst_pkg::result_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== design/asst_cfg_if.sv =====
interface asst_cfg_if;
    logic                 valid;
    logic                 ready;
    asst_pkg::cfg_write_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== design/asst_floor.sv =====
module asst_floor #(
    parameter int NOISE_ALPHA_SHIFT = 4,
    parameter int FLOOR_FRAC_BITS   = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic signed [15:0]        rssi,
    output asst_pkg::floor_view_t     view
);
    localparam int ACC_W = 16 + FLOOR_FRAC_BITS;

    logic signed [ACC_W-1:0] accum_reg;
    logic signed [ACC_W-1:0] accum_next;
    logic                    valid_reg;
    logic                    valid_next;
    logic signed [ACC_W-1:0] target;
    logic signed [ACC_W:0]   diff;
    logic signed [ACC_W:0]   delta;
    logic signed [ACC_W:0]   sum;

    assign target = ACC_W'(rssi) <<< FLOOR_FRAC_BITS;
    assign diff   = (ACC_W+1)'(target) - (ACC_W+1)'(accum_reg);
    // Arithmetic shift rounds toward minus infinity, so the average never overshoots.
    assign delta  = diff >>> NOISE_ALPHA_SHIFT;
    assign sum    = (ACC_W+1)'(accum_reg) + delta;

    always_comb
    begin
        accum_next = accum_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            accum_next = valid_reg ? sum[ACC_W-1:0] : target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            accum_reg <= accum_next;
            valid_reg <= valid_next;
        end
    end

    assign view.valid = valid_next;
    assign view.value = valid_next ? accum_next[ACC_W-1:FLOOR_FRAC_BITS] : 16'sd0;
endmodule

// ===== design/adaptive_squelch_status_tracker.sv =====
// Squelch supervisor for one radio channel. Every accepted sample transaction
// (RSSI update or status poll) produces exactly one result transaction. An
// item is registered in the input register on acceptance, evaluated against
// the channel state once the result register is empty or being read, and
// written to the result register; the result passes through the input and
// result registers. The state update is combinational, so the block takes one
// item per clock while results are read. The input register can take a new sample
// while a result waits, as long as it is empty. The configuration port is always
// ready and should be written only while no transaction is in flight.
module adaptive_squelch_status_tracker #(
    parameter int NOISE_ALPHA_SHIFT = 4,
    parameter int FLOOR_FRAC_BITS   = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    asst_sample_if.sink   sample,
    asst_result_if.source result,
    asst_cfg_if.sink      cfg
);
    // Configuration registers
    logic signed [15:0] fixed_threshold_reg;
    logic               margin_enable_reg;
    logic signed [15:0] noise_margin_reg;
    logic [31:0]        dwell_ms_reg;
    logic               hold_reg;
    logic               force_active_reg;
    logic [15:0]        debounce_ms_reg;
    logic [15:0]        report_period_ms_reg;

    // Channel state
    logic               active_flag_reg;
    logic [31:0]        last_active_time_reg;
    logic               seen_active_reg;
    logic               raw_prev_reg;
    logic [31:0]        raw_changed_time_reg;
    logic               stable_state_reg;
    logic [2:0]         last_report_status_reg;
    logic               report_valid_reg;
    logic [31:0]        last_report_time_reg;
    logic signed [15:0] pushed_threshold_reg;
    logic               pushed_valid_reg;
    logic signed [15:0] rssi_reg;

    logic               active_flag_next;
    logic [31:0]        last_active_time_next;
    logic               seen_active_next;
    logic               raw_prev_next;
    logic [31:0]        raw_changed_time_next;
    logic               stable_state_next;
    logic [2:0]         last_report_status_next;
    logic               report_valid_next;
    logic [31:0]        last_report_time_next;
    logic signed [15:0] pushed_threshold_next;
    logic               pushed_valid_next;
    logic signed [15:0] rssi_next;

    // Pipeline registers
    asst_pkg::sample_t  smp_reg;
    logic               smp_valid_reg;
    asst_pkg::result_t  res_reg;
    asst_pkg::result_t  res_next;
    logic               res_valid_reg;

    logic                  advance;
    logic                  is_poll;
    logic [31:0]           now;
    asst_pkg::floor_view_t floor_view;
    logic                  adaptive;
    logic signed [16:0]    thr_sum;
    logic signed [15:0]    thr_adaptive;
    logic signed [15:0]    thr;
    asst_pkg::status_t     status;
    logic                  changed;
    logic                  report;
    logic                  diff_status;
    logic                  periodic;

    assign advance      = smp_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !smp_valid_reg || advance;
    assign cfg.ready    = 1'b1;
    assign is_poll      = (smp_reg.command == asst_pkg::CMD_STATUS_POLL);
    assign now          = smp_reg.timestamp_ms;

    asst_floor #(
        .NOISE_ALPHA_SHIFT (NOISE_ALPHA_SHIFT),
        .FLOOR_FRAC_BITS   (FLOOR_FRAC_BITS)
    ) u_floor (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance && !is_poll && !active_flag_reg),
        .rssi  (smp_reg.rssi),
        .view  (floor_view)
    );

    assign adaptive = margin_enable_reg && floor_view.valid;
    assign thr_sum  = 17'(floor_view.value) + 17'(noise_margin_reg);

    always_comb
    begin
        if (thr_sum[16] != thr_sum[15])
            thr_adaptive = thr_sum[16] ? -16'sd32768 : 16'sd32767;
        else
            thr_adaptive = thr_sum[15:0];
    end

    assign thr = adaptive ? thr_adaptive : fixed_threshold_reg;

    always_comb
    begin
        active_flag_next        = active_flag_reg;
        last_active_time_next   = last_active_time_reg;
        seen_active_next        = seen_active_reg;
        raw_prev_next           = raw_prev_reg;
        raw_changed_time_next   = raw_changed_time_reg;
        stable_state_next       = stable_state_reg;
        last_report_status_next = last_report_status_reg;
        report_valid_next       = report_valid_reg;
        last_report_time_next   = last_report_time_reg;
        pushed_threshold_next   = pushed_threshold_reg;
        pushed_valid_next       = pushed_valid_reg;
        rssi_next               = rssi_reg;
        changed                 = 1'b0;
        report                  = 1'b0;
        diff_status             = 1'b0;
        periodic                = 1'b0;
        status                  = report_valid_reg ? asst_pkg::status_t'(last_report_status_reg)
                                                   : asst_pkg::ST_IDLE;

        if (!is_poll)
        begin
            rssi_next = smp_reg.rssi;
        end
        else
        begin
            if (adaptive && (!pushed_valid_reg || pushed_threshold_reg != thr))
            begin
                pushed_threshold_next = thr;
                pushed_valid_next     = 1'b1;
                changed               = 1'b1;
            end

            if (smp_reg.raw_unmuted != raw_prev_reg)
            begin
                raw_prev_next         = smp_reg.raw_unmuted;
                raw_changed_time_next = now;
            end
            if (smp_reg.raw_unmuted != stable_state_reg
                && (now - raw_changed_time_next) >= 32'(debounce_ms_reg))
                stable_state_next = smp_reg.raw_unmuted;

            status = hold_reg ? asst_pkg::ST_HOLD : asst_pkg::ST_IDLE;
            if (stable_state_next)
            begin
                active_flag_next      = 1'b1;
                last_active_time_next = now;
                seen_active_next      = 1'b1;
                status = force_active_reg ? asst_pkg::ST_FORCE_ACTIVE : asst_pkg::ST_ACTIVE;
            end
            else
            begin
                active_flag_next = 1'b0;
                if (seen_active_reg && (now - last_active_time_reg) < dwell_ms_reg)
                    status = asst_pkg::ST_DWELL;
            end

            diff_status = !report_valid_reg || last_report_status_reg != status;
            periodic    = status != asst_pkg::ST_IDLE
                          && (now - last_report_time_reg) > 32'(report_period_ms_reg);
            if (diff_status || periodic)
            begin
                last_report_time_next   = now;
                last_report_status_next = status;
                report_valid_next       = 1'b1;
                report                  = 1'b1;
            end
        end

        res_next.status              = status;
        res_next.report              = report;
        res_next.stable_unmuted      = stable_state_next;
        res_next.effective_threshold = thr;
        res_next.threshold_changed   = changed;
        res_next.noise_floor         = floor_view.value;
        res_next.noise_floor_valid   = floor_view.valid;
        res_next.last_rssi           = rssi_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_threshold_reg  <= asst_pkg::FIXED_THRESHOLD_RESET;
            margin_enable_reg    <= 1'b0;
            noise_margin_reg     <= asst_pkg::NOISE_MARGIN_RESET;
            dwell_ms_reg         <= '0;
            hold_reg             <= 1'b0;
            force_active_reg     <= 1'b0;
            debounce_ms_reg      <= asst_pkg::DEBOUNCE_MS_RESET;
            report_period_ms_reg <= asst_pkg::REPORT_PERIOD_MS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.item.index)
                asst_pkg::CFG_FIXED_THRESHOLD:  fixed_threshold_reg  <= cfg.item.data[15:0];
                asst_pkg::CFG_MARGIN_ENABLE:    margin_enable_reg    <= cfg.item.data[0];
                asst_pkg::CFG_NOISE_MARGIN:     noise_margin_reg     <= cfg.item.data[15:0];
                asst_pkg::CFG_DWELL_MS:         dwell_ms_reg         <= cfg.item.data;
                asst_pkg::CFG_HOLD:             hold_reg             <= cfg.item.data[0];
                asst_pkg::CFG_FORCE_ACTIVE:     force_active_reg     <= cfg.item.data[0];
                asst_pkg::CFG_DEBOUNCE_MS:      debounce_ms_reg      <= cfg.item.data[15:0];
                asst_pkg::CFG_REPORT_PERIOD_MS: report_period_ms_reg <= cfg.item.data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_flag_reg        <= 1'b0;
            last_active_time_reg   <= '0;
            seen_active_reg        <= 1'b0;
            raw_prev_reg           <= 1'b0;
            raw_changed_time_reg   <= '0;
            stable_state_reg       <= 1'b0;
            last_report_status_reg <= '0;
            report_valid_reg       <= 1'b0;
            last_report_time_reg   <= '0;
            pushed_threshold_reg   <= '0;
            pushed_valid_reg       <= 1'b0;
            rssi_reg               <= '0;
        end
        else if (advance)
        begin
            active_flag_reg        <= active_flag_next;
            last_active_time_reg   <= last_active_time_next;
            seen_active_reg        <= seen_active_next;
            raw_prev_reg           <= raw_prev_next;
            raw_changed_time_reg   <= raw_changed_time_next;
            stable_state_reg       <= stable_state_next;
            last_report_status_reg <= last_report_status_next;
            report_valid_reg       <= report_valid_next;
            last_report_time_reg   <= last_report_time_next;
            pushed_threshold_reg   <= pushed_threshold_next;
            pushed_valid_reg       <= pushed_valid_next;
            rssi_reg               <= rssi_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
                smp_valid_reg <= sample.valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
            smp_reg <= sample.item;
        if (advance)
            res_reg <= res_next;
    end

    assign result.valid = res_valid_reg;
    assign result.item  = res_reg;
endmodule
